### rtl/lbspc_pkg.sv
// ============================================================================
// lbspc_pkg
// Shared types, command codes and constants for the LED brightness store.
// ============================================================================
`default_nettype none

package lbspc_pkg;

  localparam int LEVEL_W = 8;
  localparam int SUM_W   = 14;
  localparam int CHAN_W  = 6;
  localparam int MASK_W  = 64;
  localparam int CMD_W   = 4;
  localparam int PASS_W  = 7;

  localparam logic [LEVEL_W-1:0] STEP_DOWN  = 8'd5;
  localparam logic [PASS_W-1:0]  PASS_BOUND = 7'd64;

  localparam logic [CMD_W-1:0] CMD_SET_ONE = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INC_ONE = 4'd1;
  localparam logic [CMD_W-1:0] CMD_DEC_ONE = 4'd2;
  localparam logic [CMD_W-1:0] CMD_SET_ALL = 4'd3;
  localparam logic [CMD_W-1:0] CMD_INC_ALL = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DEC_ALL = 4'd5;
  localparam logic [CMD_W-1:0] CMD_SET_GM  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_INC_GM  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DEC_GM  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_SET_SM  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_INC_SM  = 4'd10;
  localparam logic [CMD_W-1:0] CMD_DEC_SM  = 4'd11;

  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_INC = 2'd1;
  localparam logic [1:0] OP_DEC = 2'd2;

  // Per-channel control handed to the level update unit.
  typedef struct packed {
    logic                reduce;
    logic [1:0]          op;
    logic                sel;
    logic [LEVEL_W-1:0]  amount;
  } alu_ctl_t;

  // Maps a command code to the level operation it applies.
  function automatic logic [1:0] cmd_op(input logic [CMD_W-1:0] cmd);
    logic [1:0] op;
    unique case (cmd) inside
      CMD_INC_ONE, CMD_INC_ALL, CMD_INC_GM, CMD_INC_SM: op = OP_INC;
      CMD_DEC_ONE, CMD_DEC_ALL, CMD_DEC_GM, CMD_DEC_SM: op = OP_DEC;
      default:                                          op = OP_SET;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

### rtl/lbspc_level_mem.sv
// ============================================================================
// lbspc_level_mem
// Level memory: one write port, one registered read port, valid bits so that
// entries never written since reset read as zero.
// ============================================================================
`default_nettype none

module lbspc_level_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [lbspc_pkg::LEVEL_W-1:0] wdata,
  input  wire logic [AW-1:0]               raddr,
  output      logic [lbspc_pkg::LEVEL_W-1:0] rdata
);

  logic [lbspc_pkg::LEVEL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]              valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

endmodule

`default_nettype wire

### rtl/lbspc_level_alu.sv
// ============================================================================
// lbspc_level_alu
// Per-channel level update: set, increase or decrease with 8-bit wrap, or a
// limiting step that takes the step-down amount from a level above it.
// ============================================================================
`default_nettype none

module lbspc_level_alu (
  input  wire lbspc_pkg::alu_ctl_t           ctl,
  input  wire logic [lbspc_pkg::LEVEL_W-1:0] level_in,
  output      logic [lbspc_pkg::LEVEL_W-1:0] level_out,
  output      logic                          reduced
);

  always_comb begin
    level_out = level_in;
    reduced   = 1'b0;
    if (ctl.reduce) begin
      if (level_in > lbspc_pkg::STEP_DOWN) begin
        level_out = level_in - lbspc_pkg::STEP_DOWN;
        reduced   = 1'b1;
      end
    end else if (ctl.sel) begin
      case (ctl.op)
        lbspc_pkg::OP_SET: level_out = ctl.amount;
        lbspc_pkg::OP_INC: level_out = level_in + ctl.amount;
        lbspc_pkg::OP_DEC: level_out = level_in - ctl.amount;
        default:           level_out = level_in;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/led_brightness_store_power_cap.sv
// ============================================================================
// led_brightness_store_power_cap
// Per-channel LED brightness store with command updates and a power cap.
// ============================================================================
// Sequence: one update walk, one cap check state, at most 51 limiting passes,
// each a walk over all channels followed by a decide state, and then the
// emit walk, which sends one result word per channel.
// Throughput: one command at a time; the receiver cannot stall, so the words
// leave on consecutive cycles. Reset: levels read as zero through per-entry
// valid bits, power_limit resets to 16320 and global_mask to all ones.
`default_nettype none

module led_brightness_store_power_cap #(
  parameter int CHANNELS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,

  // Command channel.
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [3:0]  command,
  input  wire logic [5:0]  channel_index,
  input  wire logic [7:0]  amount,
  input  wire logic [63:0] select_mask,

  // Result channel.
  output      logic        out_valid,
  output      logic [5:0]  out_channel,
  output      logic [7:0]  out_level,
  output      logic [13:0] level_sum,
  output      logic        limit_stuck,
  output      logic        last,

  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output      logic [63:0] prdata,
  output      logic        pready
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW = $clog2(CHANNELS + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(CHANNELS - 1);
  localparam logic [CW-1:0] CH_COUNT = CW'(CHANNELS);
  localparam logic [CHANNELS-1:0] CH_ONE = CHANNELS'(1);
  localparam logic [lbspc_pkg::SUM_W-1:0] LIMIT_OFF = lbspc_pkg::SUM_W'(CHANNELS * 255);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPDATE = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_REDUCE = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  // Configuration registers. The address decode looks at bit 3 only, which
  // separates the two 64-bit register slots.
  logic [lbspc_pkg::SUM_W-1:0]  power_limit;
  logic [lbspc_pkg::MASK_W-1:0] global_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      power_limit <= LIMIT_OFF;
      global_mask <= '1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3]) begin
        global_mask <= pwdata;
      end else begin
        power_limit <= pwdata[lbspc_pkg::SUM_W-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[3] ? global_mask : 64'(power_limit);

  // Sequencer and walk registers.
  logic [2:0]                   state;
  logic [CW-1:0]                rd_cnt;
  logic                         s2_valid;
  logic [AW-1:0]                s2_idx;
  logic [CHANNELS-1:0]          sel_mask;
  logic [1:0]                   op;
  logic [lbspc_pkg::LEVEL_W-1:0] amt;
  logic [lbspc_pkg::SUM_W-1:0]  sum;
  logic                         any_reduced;
  logic [lbspc_pkg::PASS_W-1:0] pass_cnt;
  logic                         stuck;

  logic                         walking;
  logic                         issue;
  logic                         accept;
  logic [CHANNELS-1:0]          sel_mask_next;
  logic [lbspc_pkg::PASS_W-1:0] pass_cnt_next;
  logic                         limit_on;
  logic                         over;

  logic [lbspc_pkg::LEVEL_W-1:0] rdata;
  logic [lbspc_pkg::LEVEL_W-1:0] new_level;
  logic                          reduced;
  logic                          mem_we;
  lbspc_pkg::alu_ctl_t           alu_ctl;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign walking  = (state == ST_UPDATE) || (state == ST_REDUCE) || (state == ST_EMIT);
  assign issue    = walking && (rd_cnt < CH_COUNT);
  assign limit_on = (power_limit < LIMIT_OFF);
  assign over     = (sum > power_limit);
  assign pass_cnt_next = pass_cnt + 1'b1;

  // Channel selection for the accepted command, held for the whole update
  // walk. A single-channel index past the last channel shifts out to zero.
  always_comb begin
    unique case (command) inside
      lbspc_pkg::CMD_SET_ONE, lbspc_pkg::CMD_INC_ONE, lbspc_pkg::CMD_DEC_ONE:
        sel_mask_next = CH_ONE << channel_index;
      lbspc_pkg::CMD_SET_ALL, lbspc_pkg::CMD_INC_ALL, lbspc_pkg::CMD_DEC_ALL:
        sel_mask_next = '1;
      lbspc_pkg::CMD_SET_GM, lbspc_pkg::CMD_INC_GM, lbspc_pkg::CMD_DEC_GM:
        sel_mask_next = global_mask[CHANNELS-1:0];
      lbspc_pkg::CMD_SET_SM, lbspc_pkg::CMD_INC_SM, lbspc_pkg::CMD_DEC_SM:
        sel_mask_next = select_mask[CHANNELS-1:0];
      default:
        sel_mask_next = '0;
    endcase
  end

  // Stage two of a walk sees the registered read data and writes the
  // modified level back one address behind the read pointer, so a read and
  // a write never meet on the same entry within a walk.
  assign alu_ctl.reduce = (state == ST_REDUCE);
  assign alu_ctl.op     = op;
  assign alu_ctl.sel    = (state == ST_UPDATE) && sel_mask[s2_idx];
  assign alu_ctl.amount = amt;

  assign mem_we = s2_valid && ((state == ST_UPDATE) || (state == ST_REDUCE));

  lbspc_level_mem #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (s2_idx),
    .wdata (new_level),
    .raddr (rd_cnt[AW-1:0]),
    .rdata (rdata)
  );

  lbspc_level_alu u_alu (
    .ctl       (alu_ctl),
    .level_in  (rdata),
    .level_out (new_level),
    .reduced   (reduced)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_cnt   <= '0;
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= issue;
      if (issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state  <= ST_UPDATE;
            rd_cnt <= '0;
          end
        end
        ST_UPDATE: begin
          if (s2_valid && (s2_idx == LAST_IDX)) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state  <= (limit_on && over) ? ST_REDUCE : ST_EMIT;
          rd_cnt <= '0;
        end
        ST_REDUCE: begin
          if (s2_valid && (s2_idx == LAST_IDX)) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          rd_cnt <= '0;
          if (any_reduced && over && (pass_cnt_next < lbspc_pkg::PASS_BOUND)) begin
            state <= ST_REDUCE;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (s2_valid && (s2_idx == LAST_IDX)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    s2_idx <= rd_cnt[AW-1:0];
    if (accept) begin
      sel_mask <= sel_mask_next;
      op       <= lbspc_pkg::cmd_op(command);
      amt      <= amount;
      sum      <= '0;
    end
    if (mem_we) begin
      sum <= sum + lbspc_pkg::SUM_W'(new_level);
      if (reduced) begin
        any_reduced <= 1'b1;
      end
    end
    if (state == ST_CHECK) begin
      stuck       <= 1'b0;
      pass_cnt    <= '0;
      any_reduced <= 1'b0;
      if (limit_on && over) begin
        sum <= '0;
      end
    end
    if (state == ST_DECIDE) begin
      pass_cnt    <= pass_cnt_next;
      any_reduced <= 1'b0;
      // A pass that found nothing above the step-down amount leaves the sum
      // over the cap; the run ends and the flag marks it.
      stuck <= over;
      if (any_reduced && over && (pass_cnt_next < lbspc_pkg::PASS_BOUND)) begin
        sum <= '0;
      end
    end
  end

  // Result word registers: one word per channel during the emit walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_valid && (state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    out_channel <= 6'(s2_idx);
    out_level   <= rdata;
    level_sum   <= sum;
    limit_stuck <= stuck;
    last        <= (s2_idx == LAST_IDX);
  end

`ifndef SYNTHESIS
  // The emit run is contiguous: a word that is not the last is followed at
  // once by the next one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |=> out_valid)
    else $error("emit run broken before last channel");

  // The final word ends the run.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && last |=> !out_valid)
    else $error("word emitted after last channel");

  // The level memory is only written while a command is being processed.
  assert property (@(posedge clk) disable iff (rst)
    !busy |-> !mem_we)
    else $error("level memory written while idle");

  // An accepted command makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !out_valid)
    else $error("accepted command did not start processing");
`endif

endmodule

`default_nettype wire
